@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types, constants and codes of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int SHIFT_CELLS = COLUMNS * (ROWS - 1);
  localparam int ADDR_W      = $clog2(CELLS);

  // field widths
  localparam int CMD_W       = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int COLOR_W     = 4;
  localparam int CELL_W      = CHAR_W + ATTR_W;
  localparam int CFG_INDEX_W = 1;

  localparam logic [COL_W-1:0]   COL_LAST     = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]   ROW_LAST     = ROW_W'(ROWS - 1);
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  NUL_CODE     = 8'd0;
  localparam logic [COLOR_W-1:0] BACK_RESET   = 4'h0;
  localparam logic [COLOR_W-1:0] FORE_RESET   = 4'hF;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BACK_COLOR = 1'd0,
    CFG_FORE_COLOR = 1'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } tcw_state_t;

  typedef enum logic [1:0] {
    SW_INIT,
    SW_CLEAR,
    SW_SCROLL
  } sweep_mode_t;

  typedef struct packed {
    cmd_op_t            cmd;
    logic [CHAR_W-1:0]  char_code;
    logic [COL_W-1:0]   cell_col;
    logic [ROW_W-1:0]   cell_row;
  } cmd_item_t;

  typedef struct packed {
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic               scrolled;
    logic [CHAR_W-1:0]  read_char;
    logic [ATTR_W-1:0]  read_attr;
  } rsp_item_t;

  // controller to datapath
  typedef struct packed {
    logic        accept;
    logic        exec;
    logic        sweep_step;
    logic        load_out;
    sweep_mode_t mode;
  } tcw_ctrl_t;

  // datapath to controller
  typedef struct packed {
    cmd_op_t op;
    logic    needs_scroll;
    logic    sweep_last;
  } tcw_status_t;

endpackage

@@ rtl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencing of command transfers, memory sweeps and result transfers
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  input  tcw_status_t status,
  output tcw_ctrl_t   ctrl
);

  tcw_state_t  state, state_next;
  sweep_mode_t mode, mode_next;
  logic        slot_free;

  assign slot_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      mode      <= SW_INIT;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      if (ctrl.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next      = state;
    mode_next       = mode;
    cmd_ready       = 1'b0;
    ctrl.accept     = 1'b0;
    ctrl.exec       = 1'b0;
    ctrl.sweep_step = 1'b0;
    ctrl.load_out   = 1'b0;
    ctrl.mode       = mode;
    unique case (state)
      ST_SWEEP: begin
        ctrl.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_next = (mode == SW_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctrl.accept = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl.exec = 1'b1;
        if (status.op == CMD_CLEAR) begin
          mode_next  = SW_CLEAR;
          state_next = ST_SWEEP;
        end else if (status.needs_scroll) begin
          mode_next  = SW_SCROLL;
          state_next = ST_SWEEP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          ctrl.load_out = 1'b1;
          cmd_ready     = 1'b1;
          if (cmd_valid) begin
            ctrl.accept = 1'b1;
            state_next  = ST_EXEC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // no command transfer while the cell store is being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> !cmd_ready)
    else $error("command accepted during sweep");

  // every accepted command is executed in the next cycle
  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> (state == ST_EXEC))
    else $error("accepted command not executed");

  // a result never overwrites one that has not been taken
  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten");

endmodule

@@ rtl/tcw_datapath.sv @@
// ----------------------------------------------------------------------------
// tcw_datapath
// cursor, attribute registers, cell addressing and result register
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  tcw_ctrl_t                ctrl,
  output tcw_status_t              status,
  input  cmd_item_t                cmd_data,
  output rsp_item_t                rsp_data,
  input  logic                     cfg_write,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [COLOR_W-1:0]       cfg_data,
  output logic                     mem_we,
  output logic [ADDR_W-1:0]        mem_waddr,
  output logic [CELL_W-1:0]        mem_wdata,
  output logic                     mem_re,
  output logic [ADDR_W-1:0]        mem_raddr,
  input  logic [CELL_W-1:0]        mem_rdata
);

  logic [COLOR_W-1:0] back_color, fore_color;
  logic [ATTR_W-1:0]  attr;
  logic [CELL_W-1:0]  blank;

  cmd_op_t            lat_op;
  logic [CHAR_W-1:0]  lat_char;
  logic [COL_W-1:0]   lat_col;
  logic [ROW_W-1:0]   lat_row;

  logic [COL_W-1:0]   cursor_col;
  logic [ROW_W-1:0]   cursor_row;
  logic               scrolled;
  logic [CHAR_W-1:0]  rd_char;
  logic [ATTR_W-1:0]  rd_attr;
  logic [ADDR_W-1:0]  sweep_cnt;

  logic [COL_W-1:0]   in_col_sat;
  logic [ROW_W-1:0]   in_row_sat;
  logic [ADDR_W-1:0]  in_addr, cursor_addr;
  logic [ADDR_W:0]    sweep_raddr;
  logic               is_newline, line_end;

  assign attr  = {back_color, fore_color};
  assign blank = {attr, NUL_CODE};

  assign in_col_sat = (cmd_data.cell_col > COL_LAST) ? COL_LAST : cmd_data.cell_col;
  assign in_row_sat = (cmd_data.cell_row > ROW_LAST) ? ROW_LAST : cmd_data.cell_row;
  assign in_addr = ADDR_W'(in_row_sat) * ADDR_W'(COLUMNS) + ADDR_W'(in_col_sat);
  assign cursor_addr = ADDR_W'(cursor_row) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col);

  assign is_newline = (lat_char == NEWLINE_CODE);
  assign line_end   = is_newline || (cursor_col == COL_LAST);

  assign status.op           = lat_op;
  assign status.needs_scroll = (lat_op == CMD_PUT) && line_end && (cursor_row == ROW_LAST);
  assign status.sweep_last   = (sweep_cnt == ADDR_W'(CELLS - 1));

  assign sweep_raddr = (ADDR_W + 1)'(sweep_cnt) + (ADDR_W + 1)'(COLUMNS + 1);

  // memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cursor_addr;
    mem_wdata = {attr, lat_char};
    mem_re    = 1'b0;
    mem_raddr = in_addr;
    if (ctrl.accept) begin
      mem_re = 1'b1;
    end else if (ctrl.exec) begin
      mem_we    = (lat_op == CMD_PUT) && !is_newline;
      // prefetch the first source cell of a scroll
      mem_re    = status.needs_scroll;
      mem_raddr = ADDR_W'(COLUMNS);
    end else if (ctrl.sweep_step) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_cnt;
      mem_re    = (ctrl.mode == SW_SCROLL) && (sweep_raddr < (ADDR_W + 1)'(CELLS));
      mem_raddr = sweep_raddr[ADDR_W-1:0];
      unique case (ctrl.mode)
        SW_INIT:   mem_wdata = '0;
        SW_CLEAR:  mem_wdata = blank;
        SW_SCROLL: mem_wdata = (sweep_cnt < ADDR_W'(SHIFT_CELLS)) ? mem_rdata : blank;
        default:   mem_wdata = '0;
      endcase
    end
  end

  // control-like state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      back_color <= BACK_RESET;
      fore_color <= FORE_RESET;
      cursor_col <= '0;
      cursor_row <= '0;
      sweep_cnt  <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_BACK_COLOR: back_color <= cfg_data;
          CFG_FORE_COLOR: fore_color <= cfg_data;
          default: ;
        endcase
      end
      if (ctrl.exec) begin
        sweep_cnt <= '0;
      end else if (ctrl.sweep_step) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
      if (ctrl.exec) begin
        unique case (lat_op)
          CMD_PUT: begin
            if (line_end) begin
              cursor_col <= '0;
              if (cursor_row != ROW_LAST) begin
                cursor_row <= cursor_row + 1'b1;
              end
            end else begin
              cursor_col <= cursor_col + 1'b1;
            end
          end
          CMD_SET: begin
            cursor_col <= lat_col;
            cursor_row <= lat_row;
          end
          CMD_CLEAR: begin
            cursor_col <= '0;
            cursor_row <= '0;
          end
          CMD_READ: ;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      lat_op   <= cmd_data.cmd;
      lat_char <= cmd_data.char_code;
      lat_col  <= in_col_sat;
      lat_row  <= in_row_sat;
    end
    if (ctrl.exec) begin
      scrolled <= status.needs_scroll;
      if (lat_op == CMD_READ) begin
        rd_char <= mem_rdata[CHAR_W-1:0];
        rd_attr <= mem_rdata[CELL_W-1:CHAR_W];
      end else begin
        rd_char <= '0;
        rd_attr <= '0;
      end
    end
    if (ctrl.load_out) begin
      rsp_data.cursor_col <= cursor_col;
      rsp_data.cursor_row <= cursor_row;
      rsp_data.scrolled   <= scrolled;
      rsp_data.read_char  <= rd_char;
      rsp_data.read_attr  <= rd_attr;
    end
  end

  // cursor always stays on the screen
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (cursor_col <= COL_LAST) && (cursor_row <= ROW_LAST))
    else $error("cursor off screen");

  // a scroll leaves the cursor on the bottom row and flags it
  a_scroll_bottom_row: assert property (@(posedge clk) disable iff (rst)
    (ctrl.exec && status.needs_scroll) |=> ((cursor_row == ROW_LAST) && scrolled))
    else $error("scroll did not settle on bottom row");

endmodule

@@ rtl/text_console_writer_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_unit
// character-cell console engine with cursor, scrolling and cell readback
// ----------------------------------------------------------------------------
//
//   channel   signals                              direction   payload
//   cmd       cmd_valid / cmd_ready / cmd_data     to unit     cmd_item_t
//   rsp       rsp_valid / rsp_ready / rsp_data     from unit   rsp_item_t
//   cfg       cfg_valid / cfg_ready / cfg_index,   to unit     color nibble
//             cfg_data
//
// put, set cursor and read pass through a transfer step, which also reads
// the cell, and an execute step; the result register then loads while the
// next command transfer is taken
// clear and a scroll that passes the last row add one write per cell
// (COLUMNS*ROWS cells, 2000 here), bound by the single write port of the
// cell store
// after reset a clearing pass over all COLUMNS*ROWS cells zeroes the store,
// cmd_ready is low meanwhile; cfg writes are taken in every cycle
// a stalled result holds the unit in its result state, one command deep
//
module text_console_writer_unit import tcw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // command channel
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  cmd_item_t              cmd_data,
  // result channel
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output rsp_item_t              rsp_data,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]     cfg_data
);

  tcw_ctrl_t          ctrl;
  tcw_status_t        status;

  // cell store port signals
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [CELL_W-1:0]  mem_rdata;

  // color registers never stall a transfer
  assign cfg_ready = 1'b1;

  // state machine: transfers, execution and sweeps
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  // cursor, attribute, addressing and result register
  tcw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .cmd_data  (cmd_data),
    .rsp_data  (rsp_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // screen store: char in low byte, attribute in high byte
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ test/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// watches the command, result and color write channels of the console
// writer, keeps its own copy of the screen, cursor and colors, predicts one
// result per command transfer and compares each result transfer against the
// oldest prediction
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  logic                   cmd_ready,
  input  cmd_item_t              cmd_data,
  input  logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  rsp_item_t              rsp_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]     cfg_data,
  output int                     fail_count,
  output int                     pending_count
);

  // screen image: attribute in the upper byte, character in the lower
  logic [CELL_W-1:0]  cells [CELLS];
  int                 cur_col;
  int                 cur_row;
  logic [COLOR_W-1:0] back_nib;
  logic [COLOR_W-1:0] fore_nib;
  rsp_item_t          expected_rsp [$];
  int                 reported;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    reported      = 0;
  end

  // applies one command to the screen image, returns the result it yields
  function automatic rsp_item_t console_step(cmd_item_t c);
    rsp_item_t         r;
    int                col_sel;
    int                row_sel;
    logic [CELL_W-1:0] blank;
    blank   = {back_nib, fore_nib, NUL_CODE};
    r       = '0;
    col_sel = (c.cell_col > COL_LAST) ? COL_LAST : c.cell_col;
    row_sel = (c.cell_row > ROW_LAST) ? ROW_LAST : c.cell_row;
    case (c.cmd)
      CMD_PUT: begin
        if (c.char_code == NEWLINE_CODE) begin
          cur_col = 0;
          cur_row++;
        end else begin
          cells[cur_row * COLUMNS + cur_col] = {back_nib, fore_nib, c.char_code};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // ran off the bottom: shift everything up one row
        if (cur_row >= ROWS) begin
          for (int i = 0; i < SHIFT_CELLS; i++) cells[i] = cells[i + COLUMNS];
          for (int i = SHIFT_CELLS; i < CELLS; i++) cells[i] = blank;
          cur_row    = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      CMD_SET: begin
        cur_col = col_sel;
        cur_row = row_sel;
      end
      CMD_CLEAR: begin
        foreach (cells[i]) cells[i] = blank;
        cur_col = 0;
        cur_row = 0;
      end
      CMD_READ: begin
        {r.read_attr, r.read_char} = cells[row_sel * COLUMNS + col_sel];
      end
      default: ;
    endcase
    r.cursor_col = COL_W'(cur_col);
    r.cursor_row = ROW_W'(cur_row);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rsp_item_t want;
    if (rst) begin
      foreach (cells[i]) cells[i] = '0;
      cur_col  = 0;
      cur_row  = 0;
      back_nib = BACK_RESET;
      fore_nib = FORE_RESET;
      expected_rsp.delete();
    end else begin
      // results first, a command never answers in its own transfer cycle
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected result col %0d row %0d scr %0b char %h attr %h",
                     $time, rsp_data.cursor_col, rsp_data.cursor_row,
                     rsp_data.scrolled, rsp_data.read_char, rsp_data.read_attr);
          end
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_data !== want) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch exp col %0d row %0d scr %0b char %h attr %h",
                       $time, want.cursor_col, want.cursor_row, want.scrolled,
                       want.read_char, want.read_attr);
              $display("%0t:          got col %0d row %0d scr %0b char %h attr %h",
                       $time, rsp_data.cursor_col, rsp_data.cursor_row,
                       rsp_data.scrolled, rsp_data.read_char, rsp_data.read_attr);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BACK_COLOR: back_nib = cfg_data;
          CFG_FORE_COLOR: fore_nib = cfg_data;
          default: ;
        endcase
      end
      if (cmd_valid && cmd_ready) expected_rsp.push_back(console_step(cmd_data));
    end
    pending_count = expected_rsp.size();
  end

endmodule

@@ test/text_console_writer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_unit_tb
// drives the console writer with a directed burst of corner cases and then
// random command streams under three idling patterns, changing colors
// between streams; a checker beside the unit predicts and compares results
// ----------------------------------------------------------------------------
module text_console_writer_unit_tb;
  import tcw_pkg::*;

  // cycles without any transfer before the run is declared hung; the longest
  // legal gap is one clear or scroll sweep (or the clearing pass after reset)
  localparam int STALL_LIMIT = 20000;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cmd_valid = 1'b0;
  logic                   cmd_ready;
  cmd_item_t              cmd_data  = '0;
  logic                   rsp_valid;
  logic                   rsp_ready = 1'b0;
  rsp_item_t              rsp_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]     cfg_data  = '0;

  int fail_count;
  int pending_count;
  int quiet_cycles = 0;

  // idle percentages of the sender and the receiver
  int tx_idle = 15;
  int rx_idle = 63;

  always #5 clk = ~clk;

  text_console_writer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tcw_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd_data      (cmd_data),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp_data      (rsp_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= rx_idle);
  end

  // hang detector: any transfer on any channel resets the count
  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic cmd_item_t pack_cmd(cmd_op_t op, logic [CHAR_W-1:0] ch,
                                         logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    cmd_item_t c;
    c.cmd       = op;
    c.char_code = ch;
    c.cell_col  = col;
    c.cell_row  = row;
    return c;
  endfunction

  // one command transfer; entered just after a rising edge, returns at the
  // rising edge of the transfer with valid still high so back-to-back
  // commands keep it asserted
  task automatic push_cmd(cmd_item_t c);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= c;
    do @(posedge clk); while (!cmd_ready);
  endtask

  // drop valid and hold off until every predicted result has come back
  task automatic drain_results();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // color register write, only issued with the unit drained
  task automatic write_color(cfg_index_t idx, logic [COLOR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // coordinates: mostly on screen and often near the bottom right so that
  // wraps and scrolls come up, sometimes anywhere the field can hold
  function automatic logic [COL_W-1:0] pick_col();
    case ($urandom_range(3))
      0:       return COL_W'($urandom_range(127));
      1:       return COL_W'($urandom_range(COLUMNS - 1, COLUMNS - 4));
      default: return COL_W'($urandom_range(COLUMNS - 1));
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] pick_row();
    case ($urandom_range(3))
      0:       return ROW_W'($urandom_range(31));
      1:       return ROW_W'($urandom_range(ROWS - 1, ROWS - 3));
      default: return ROW_W'($urandom_range(ROWS - 1));
    endcase
  endfunction

  // random command stream: mostly character puts with some newlines, cursor
  // moves and cell reads, the occasional clear, and now and then a full drain
  task automatic random_stream(int count);
    int                pick;
    logic [CHAR_W-1:0] ch;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      ch   = CHAR_W'($urandom_range(255));
      if (pick < 55) begin
        if ($urandom_range(99) < 12) ch = NEWLINE_CODE;
        push_cmd(pack_cmd(CMD_PUT, ch, COL_W'($urandom_range(127)),
                          ROW_W'($urandom_range(31))));
      end else if (pick < 70) begin
        push_cmd(pack_cmd(CMD_SET, ch, pick_col(), pick_row()));
      end else if (pick < 97) begin
        push_cmd(pack_cmd(CMD_READ, ch, pick_col(), pick_row()));
      end else begin
        push_cmd(pack_cmd(CMD_CLEAR, ch, COL_W'($urandom_range(127)),
                          ROW_W'($urandom_range(31))));
      end
      if ($urandom_range(99) < 3) drain_results();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corner cases with the reset colors
    push_cmd(pack_cmd(CMD_READ, 8'h00, 7'd0, 5'd0));       // store zero after reset
    push_cmd(pack_cmd(CMD_PUT, 8'h41, 7'd0, 5'd0));
    push_cmd(pack_cmd(CMD_PUT, 8'h00, 7'd0, 5'd0));        // lowest character code
    push_cmd(pack_cmd(CMD_PUT, 8'hFF, 7'd127, 5'd31));     // highest character code
    push_cmd(pack_cmd(CMD_READ, 8'hFF, 7'd0, 5'd0));
    push_cmd(pack_cmd(CMD_READ, 8'h00, 7'd2, 5'd0));
    push_cmd(pack_cmd(CMD_SET, 8'h00, 7'd127, 5'd31));     // saturates to last cell
    push_cmd(pack_cmd(CMD_READ, 8'h00, 7'd127, 5'd31));    // saturated read
    push_cmd(pack_cmd(CMD_PUT, 8'h78, 7'd0, 5'd0));        // wrap past last cell scrolls
    push_cmd(pack_cmd(CMD_READ, 8'h00, 7'd79, 5'd23));     // moved up one row
    push_cmd(pack_cmd(CMD_READ, 8'h00, 7'd0, 5'd24));      // blanked bottom row
    push_cmd(pack_cmd(CMD_SET, 8'h00, 7'd79, 5'd3));
    push_cmd(pack_cmd(CMD_PUT, 8'h5A, 7'd0, 5'd0));        // column wrap, no scroll
    push_cmd(pack_cmd(CMD_SET, 8'h00, 7'd80, 5'd25));      // just past both limits
    push_cmd(pack_cmd(CMD_SET, 8'h00, 7'd5, 5'd24));
    push_cmd(pack_cmd(CMD_PUT, NEWLINE_CODE, 7'd0, 5'd0)); // newline on last row scrolls
    push_cmd(pack_cmd(CMD_PUT, NEWLINE_CODE, 7'd0, 5'd0)); // and again from the bottom
    push_cmd(pack_cmd(CMD_SET, 8'h00, 7'd0, 5'd10));
    push_cmd(pack_cmd(CMD_PUT, NEWLINE_CODE, 7'd0, 5'd0)); // plain newline
    push_cmd(pack_cmd(CMD_CLEAR, 8'h00, 7'd0, 5'd0));
    push_cmd(pack_cmd(CMD_READ, 8'h00, 7'd79, 5'd24));

    // opposite color extremes, then clear so blanks carry the new attribute
    drain_results();
    write_color(CFG_BACK_COLOR, 4'hF);
    write_color(CFG_FORE_COLOR, 4'h0);
    push_cmd(pack_cmd(CMD_CLEAR, 8'h00, 7'd0, 5'd0));
    push_cmd(pack_cmd(CMD_READ, 8'h00, 7'd40, 5'd12));
    push_cmd(pack_cmd(CMD_PUT, 8'hA5, 7'd0, 5'd0));
    push_cmd(pack_cmd(CMD_READ, 8'h00, 7'd0, 5'd0));

    // first stream: sender idles lightly, receiver heavily
    drain_results();
    write_color(CFG_BACK_COLOR, COLOR_W'($urandom_range(15)));
    write_color(CFG_FORE_COLOR, COLOR_W'($urandom_range(15)));
    random_stream(130);

    // second stream: roles swapped, both nibbles at the top
    drain_results();
    tx_idle = 63;
    rx_idle = 15;
    write_color(CFG_BACK_COLOR, 4'hF);
    write_color(CFG_FORE_COLOR, 4'hF);
    random_stream(130);

    // third stream: no idling at all, both nibbles at zero
    drain_results();
    tx_idle = 0;
    rx_idle = 0;
    write_color(CFG_BACK_COLOR, 4'h0);
    write_color(CFG_FORE_COLOR, 4'h0);
    random_stream(140);

    // let the last results come home, then watch for strays
    drain_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ text_console_writer_unit.f @@
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_writer_unit.sv
test/tcw_checker.sv
test/text_console_writer_unit_tb.sv
